// ===== sv/set_assoc_cache_hit_miss_model_assert.svh =====
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_CACHE_HIT_MISS_MODEL_ASSERT_SVH
`define SET_ASSOC_CACHE_HIT_MISS_MODEL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while arst_n is low
`define SAC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache model: same-cycle check failed");
// next-cycle implication, sampled on clk, off while arst_n is low
`define SAC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache model: next-cycle check failed");
`else
`define SAC_ASSERT_IMP(label, ante, cons)
`define SAC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/sac_pkg.sv =====
// Shared types, codes and helpers of the set-associative cache model.
`default_nettype none
package sac_pkg;

	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_WAYS         = 8;
	localparam int DEF_ADDR_BITS    = 64;

	localparam int RANK_W       = 4;
	localparam int CNT_W        = 32;
	localparam int CMD_W        = 2;
	localparam int OUTCOME_W    = 2;
	localparam int SET_BITS_W   = 3;
	localparam int BLOCK_BITS_W = 6;
	localparam int WAYS_USED_W  = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 6;

	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CMD_W-1:0]     cmd_t;
	typedef logic [OUTCOME_W-1:0] outcome_t;

	// trace commands
	localparam cmd_t CMD_FETCH  = 2'd0;
	localparam cmd_t CMD_LOAD   = 2'd1;
	localparam cmd_t CMD_STORE  = 2'd2;
	localparam cmd_t CMD_MODIFY = 2'd3;

	// access outcomes
	localparam outcome_t OUT_HIT        = 2'd0;
	localparam outcome_t OUT_MISS       = 2'd1;
	localparam outcome_t OUT_MISS_EVICT = 2'd2;
	localparam outcome_t OUT_IGNORED    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 3'd3;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	function automatic rank_t rank_inc(input rank_t r);
		return (r == '1) ? r : rank_t'(r + rank_t'(1));
	endfunction

	function automatic cnt_t cnt_inc(input cnt_t c);
		return (c == '1) ? c : cnt_t'(c + cnt_t'(1));
	endfunction

endpackage
`default_nettype wire

// ===== sv/sac_set_store.sv =====
// Set-row store: valid, tag and rank of every way of one set per row.
`default_nettype none
module sac_set_store #(
	parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
	parameter int WAYS         = sac_pkg::DEF_WAYS,
	parameter int TAG_W        = sac_pkg::DEF_ADDR_BITS - 1
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    rd_en,
	input  wire  [MAX_SET_BITS-1:0]                rd_addr,
	output logic [WAYS-1:0]                        rd_valid,
	output logic [WAYS-1:0][TAG_W-1:0]             rd_tag,
	output sac_pkg::rank_t [WAYS-1:0]              rd_rank,
	input  wire                                    wr_en,
	input  wire  [MAX_SET_BITS-1:0]                wr_addr,
	input  wire  [WAYS-1:0]                        wr_valid,
	input  wire  [WAYS-1:0][TAG_W-1:0]             wr_tag,
	input  wire  [WAYS-1:0][sac_pkg::RANK_W-1:0]   wr_rank
);
	import sac_pkg::*;

	localparam int NUM_SETS = 1 << MAX_SET_BITS;

	logic [WAYS-1:0]             valid_mem [NUM_SETS];
	logic [WAYS-1:0][TAG_W-1:0]  tag_mem   [NUM_SETS];
	rank_t [WAYS-1:0]            rank_mem  [NUM_SETS];

	// one flag per row: a row never written reads as all zero
	logic [NUM_SETS-1:0]         row_written_q;
	logic                        rd_written_q;

	logic [WAYS-1:0]             rd_valid_q;
	logic [WAYS-1:0][TAG_W-1:0]  rd_tag_q;
	rank_t [WAYS-1:0]            rd_rank_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			valid_mem[wr_addr] <= wr_valid;
			tag_mem[wr_addr]   <= wr_tag;
			rank_mem[wr_addr]  <= wr_rank;
		end
		if (rd_en) begin
			rd_valid_q <= valid_mem[rd_addr];
			rd_tag_q   <= tag_mem[rd_addr];
			rd_rank_q  <= rank_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_written_q <= '0;
			rd_written_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= row_written_q[rd_addr];
			end
		end
	end

	assign rd_valid = rd_written_q ? rd_valid_q : '0;
	assign rd_tag   = rd_written_q ? rd_tag_q   : '0;
	assign rd_rank  = rd_written_q ? rd_rank_q  : '0;

endmodule
`default_nettype wire

// ===== sv/set_assoc_cache_hit_miss_model.sv =====
// A load or store is indexed, then scanned one way at a time over the ways in use until a
// tag match, then updated and emitted through the output register; a modify runs this twice
// and gives two results, and a fetch goes straight to emit. A new trace item is taken only
// when idle, after the last result of the current one is loaded; output stalls hold emit.
// Reset (arst_n low, async): lines read invalid, totals zero, registers at defaults;
// per-row written flags make untouched rows read empty, so no clearing pass is needed.
`default_nettype none
module set_assoc_cache_hit_miss_model #(
	parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
	parameter int WAYS         = sac_pkg::DEF_WAYS,
	parameter int ADDR_BITS    = sac_pkg::DEF_ADDR_BITS,
	parameter int IN_W         = ((ADDR_BITS + 1 + 7) / 8) * 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration write channel
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [sac_pkg::CFG_DATA_W-1:0]   cfg_data,
	// trace input
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// s_axis_tdata: command [1:0], address [ADDR_BITS:2], zero fill above
	input  wire  [IN_W-1:0]                  s_axis_tdata,
	// access results
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// m_axis_tdata: outcome [1:0], hit_total [33:2], miss_total [65:34],
	// eviction_total [97:66], zero fill [103:98]
	output logic [103:0]                     m_axis_tdata,
	output logic                             m_axis_tlast
);
	import sac_pkg::*;

	localparam int ADDR_W  = ADDR_BITS - 1;
	localparam int TAG_W   = ADDR_W;
	localparam int SET_W   = MAX_SET_BITS;
	localparam int SB_W    = $clog2(MAX_SET_BITS + 1);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W  = $clog2(WAYS + 1);
	localparam int OUT_PAD = 104 - (OUTCOME_W + 3 * CNT_W);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INDEX  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	// configuration registers
	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;
	logic [WAYS_USED_W-1:0]  ways_used_q;
	logic                    policy_q;

	logic [2:0]              state_q;
	cmd_t                    cmd_q;
	logic                    second_q;      // second access of a modify
	logic [ADDR_W-1:0]       above_q;       // address with block offset dropped
	logic [SET_W-1:0]        set_q;
	logic [TAG_W-1:0]        tag_q;

	// scan results
	logic [WAY_W-1:0]        w_q;
	logic                    hit_q;
	logic [WAY_W-1:0]        hit_way_q;
	logic                    inv_found_q;
	logic [WAY_W-1:0]        inv_way_q;
	rank_t                   best_q;
	logic [WAY_W-1:0]        max_way_q;
	outcome_t                outcome_q;

	cnt_t                    hits_q;
	cnt_t                    misses_q;
	cnt_t                    evicts_q;

	// output register
	logic                    o_valid_q;
	outcome_t                o_outcome_q;
	logic                    o_last_q;
	cnt_t                    o_hits_q;
	cnt_t                    o_misses_q;
	cnt_t                    o_evicts_q;

	// store interface
	logic                         rd_en;
	logic [WAYS-1:0]              rd_valid;
	logic [WAYS-1:0][TAG_W-1:0]   rd_tag;
	rank_t [WAYS-1:0]             rd_rank;
	logic                         wr_en;
	logic [WAYS-1:0]              new_valid;
	logic [WAYS-1:0][TAG_W-1:0]   new_tag;
	rank_t [WAYS-1:0]             new_rank;

	logic [SB_W-1:0]         sb_c;
	logic [WCNT_W-1:0]       nw_c;
	logic [SET_W-1:0]        set_c;
	logic [TAG_W-1:0]        tag_c;
	logic                    s_take;
	cmd_t                    in_cmd;
	logic [ADDR_W-1:0]       in_addr;
	logic                    way_match;
	logic                    way_last;
	logic [WAY_W-1:0]        victim;
	rank_t                   hit_rank;
	logic                    emit_load;
	logic                    emit_last;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_take        = s_axis_tvalid && s_axis_tready;
	assign in_cmd        = s_axis_tdata[CMD_W-1:0];
	assign in_addr       = s_axis_tdata[CMD_W +: ADDR_W];

	// effective set bits and ways in use
	assign sb_c = (int'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
	                                                : SB_W'(set_bits_q);
	always_comb begin
		if (ways_used_q == '0) begin
			nw_c = WCNT_W'(1);
		end else if (int'(ways_used_q) > WAYS) begin
			nw_c = WCNT_W'(WAYS);
		end else begin
			nw_c = WCNT_W'(ways_used_q);
		end
	end

	assign set_c = above_q[SET_W-1:0] & ~({SET_W{1'b1}} << sb_c);
	assign tag_c = above_q >> sb_c;

	// shared way compare unit: one way per cycle
	assign way_match = rd_valid[w_q] && (rd_tag[w_q] == tag_q);
	assign way_last  = (WCNT_W'(w_q) + WCNT_W'(1)) == nw_c;

	assign victim   = inv_found_q ? inv_way_q : max_way_q;
	assign hit_rank = rd_rank[hit_way_q];

	// row rewrite after the scan
	always_comb begin
		new_valid = rd_valid;
		new_tag   = rd_tag;
		new_rank  = rd_rank;
		for (int j = 0; j < WAYS; j++) begin
			if (WCNT_W'(j) < nw_c) begin
				if (hit_q) begin
					if (rd_rank[j] < hit_rank) begin
						new_rank[j] = rank_inc(rd_rank[j]);
					end
				end else if (rd_valid[j]) begin
					new_rank[j] = rank_inc(rd_rank[j]);
				end
			end
		end
		if (hit_q) begin
			new_rank[hit_way_q] = '0;
		end else begin
			new_valid[victim] = 1'b1;
			new_tag[victim]   = tag_q;
			new_rank[victim]  = '0;
		end
	end

	assign rd_en = (state_q == S_INDEX);
	// FIFO hits leave the row as it is
	assign wr_en = (state_q == S_UPDATE) && !(hit_q && (policy_q == POLICY_FIFO));

	assign emit_load = (state_q == S_EMIT) && (!o_valid_q || m_axis_tready);
	assign emit_last = (cmd_q != CMD_MODIFY) || second_q;

	sac_set_store #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.WAYS         (WAYS),
		.TAG_W        (TAG_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (set_c),
		.rd_valid (rd_valid),
		.rd_tag   (rd_tag),
		.rd_rank  (rd_rank),
		.wr_en    (wr_en),
		.wr_addr  (set_q),
		.wr_valid (new_valid),
		.wr_tag   (new_tag),
		.wr_rank  (new_rank)
	);

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_W'(1);
			block_bits_q <= BLOCK_BITS_W'(1);
			ways_used_q  <= WAYS_USED_W'(1);
			policy_q     <= POLICY_LRU;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[SET_BITS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BLOCK_BITS_W-1:0];
				CFG_WAYS_USED:  ways_used_q  <= cfg_data[WAYS_USED_W-1:0];
				CFG_POLICY:     policy_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_FETCH;
			second_q    <= 1'b0;
			set_q       <= '0;
			tag_q       <= '0;
			hit_q       <= 1'b0;
			hit_way_q   <= '0;
			inv_found_q <= 1'b0;
			inv_way_q   <= '0;
			best_q      <= '0;
			max_way_q   <= '0;
			outcome_q   <= OUT_HIT;
			w_q         <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_take) begin
						cmd_q    <= in_cmd;
						second_q <= 1'b0;
						if (in_cmd == CMD_FETCH) begin
							outcome_q <= OUT_IGNORED;
							state_q   <= S_EMIT;
						end else begin
							state_q <= S_INDEX;
						end
					end
				end
				S_INDEX: begin
					set_q       <= set_c;
					tag_q       <= tag_c;
					w_q         <= '0;
					hit_q       <= 1'b0;
					inv_found_q <= 1'b0;
					state_q     <= S_SCAN;
				end
				S_SCAN: begin
					if (way_match) begin
						hit_q     <= 1'b1;
						hit_way_q <= w_q;
						state_q   <= S_UPDATE;
					end else begin
						if (!rd_valid[w_q] && !inv_found_q) begin
							inv_found_q <= 1'b1;
							inv_way_q   <= w_q;
						end
						// first way holding the highest rank
						if (w_q == '0 || rd_rank[w_q] > best_q) begin
							best_q    <= rd_rank[w_q];
							max_way_q <= w_q;
						end
						if (way_last) begin
							state_q <= S_UPDATE;
						end else begin
							w_q <= WAY_W'(w_q + WAY_W'(1));
						end
					end
				end
				S_UPDATE: begin
					if (hit_q) begin
						hits_q    <= cnt_inc(hits_q);
						outcome_q <= OUT_HIT;
					end else begin
						misses_q <= cnt_inc(misses_q);
						if (inv_found_q) begin
							outcome_q <= OUT_MISS;
						end else begin
							evicts_q  <= cnt_inc(evicts_q);
							outcome_q <= OUT_MISS_EVICT;
						end
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							second_q <= 1'b1;
							state_q  <= S_INDEX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// offset strip happens on acceptance
	always_ff @(posedge clk) begin
		if (s_take) begin
			above_q <= in_addr >> block_bits_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (emit_load) begin
			o_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			o_outcome_q <= outcome_q;
			o_last_q    <= emit_last;
			o_hits_q    <= hits_q;
			o_misses_q  <= misses_q;
			o_evicts_q  <= evicts_q;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, o_evicts_q, o_misses_q, o_hits_q, o_outcome_q};

`include "set_assoc_cache_hit_miss_model_assert.svh"

	// a fresh transaction always starts the sequencer
	`SAC_ASSERT_NXT(a_take_busy, s_take, state_q != S_IDLE)
	// scan pointer stays within the ways in use
	`SAC_ASSERT_IMP(a_scan_range, state_q == S_SCAN, WCNT_W'(w_q) < nw_c)
	// the row write-back comes only from the update step
	`SAC_ASSERT_IMP(a_wr_update, wr_en, state_q == S_UPDATE && !rd_en)
	// a result loaded into an empty output register shows up next cycle
	`SAC_ASSERT_NXT(a_emit_out, emit_load, m_axis_tvalid)

endmodule
`default_nettype wire
